[rtl/core/pjs_pkg.sv]
// package: types, constants and status codes of the priority job slice scheduler
package pjs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_RAN   = 3'd1,
      ST_FINAL = 3'd2,
      ST_ADDED = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_ADD  = 1'b1
   } action_type;

   typedef struct packed {
      logic [7:0]  tag;
      logic [15:0] length;
      logic [15:0] key;
   } slot_type;

   typedef struct packed {
      logic [7:0]  job_tag;
      logic [15:0] job_length;
      logic [15:0] job_priority;
      logic        action;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  running_tag;
      logic [15:0] remaining_length;
      logic [4:0]  queued_count;
   } rsp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;      // capture request
      logic search;    // step one search compare
      logic insert;    // shift-write insert
      logic pop;       // remove head
      logic dec;       // decrement head
      logic respond;   // load response register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_add;
      logic full;
      logic empty;
      logic search_done;
      logic head_final;
   } stat_type;

endpackage

[rtl/core/pjs_if.sv]
// valid/ready channel interfaces for requests and responses
interface pjs_req_if;
   logic             valid;
   logic             ready;
   pjs_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pjs_rsp_if;
   logic             valid;
   logic             ready;
   pjs_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/pjs_datapath.sv]
// datapath: sorted job store, insertion search, response register
module pjs_datapath (
   input  logic               clock,
   input  logic               reset,
   input  pjs_pkg::req_type   req_payload,
   input  pjs_pkg::cmd_type   cmd,
   output pjs_pkg::stat_type  stat,
   output pjs_pkg::rsp_type   rsp_payload
);

   pjs_pkg::slot_type             job_entries_ff [pjs_pkg::QUEUE_DEPTH];
   logic [pjs_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [pjs_pkg::CNT_W-1:0]     pos_ff, pos_in;
   logic                          done_ff, done_in;
   pjs_pkg::req_type              req_ff;
   pjs_pkg::rsp_type              rsp_ff;
   logic [15:0]                   new_key;
   pjs_pkg::slot_type             new_slot;
   pjs_pkg::slot_type             head;
   pjs_pkg::slot_type             probe;
   logic                          final_slice;

   assign new_key  = req_ff.job_priority ^ 16'h8000;
   assign new_slot = '{tag: req_ff.job_tag, length: req_ff.job_length, key: new_key};
   assign head     = job_entries_ff[0];
   assign probe    = job_entries_ff[pos_ff[pjs_pkg::IDX_W-1:0]];
   assign final_slice = (head.length <= 16'd1);

   // status to controller
   assign stat.is_add      = req_ff.action == pjs_pkg::ACT_ADD;
   assign stat.full        = count_ff == pjs_pkg::CNT_W'(pjs_pkg::QUEUE_DEPTH);
   assign stat.empty       = count_ff == '0;
   assign stat.search_done = done_ff;
   assign stat.head_final  = final_slice;
   assign rsp_payload      = rsp_ff;

   // search position and count
   always_comb begin
      pos_in   = pos_ff;
      done_in  = done_ff;
      count_in = count_ff;
      if (cmd.load) begin
         pos_in  = '0;
         done_in = 1'b0;
      end else if (cmd.search && !done_ff) begin
         if (pos_ff >= count_ff || probe.key > new_key) begin
            done_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
         done_ff  <= done_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
   end

   // store shifting: insert moves tail up, pop moves all down
   always_ff @(posedge clock) begin
      for (int i = 0; i < pjs_pkg::QUEUE_DEPTH; i++) begin
         if (cmd.insert) begin
            if (pjs_pkg::CNT_W'(i) == pos_ff) begin
               job_entries_ff[i] <= new_slot;
            end else if (pjs_pkg::CNT_W'(i) > pos_ff && i > 0) begin
               job_entries_ff[i] <= job_entries_ff[i-1];
            end
         end else if (cmd.pop) begin
            if (i < pjs_pkg::QUEUE_DEPTH - 1) begin
               job_entries_ff[i] <= job_entries_ff[i+1];
            end
         end else if (cmd.dec && i == 0) begin
            job_entries_ff[0].length <= head.length - 16'd1;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.running_tag      <= 8'd0;
         rsp_ff.remaining_length <= 16'd0;
         rsp_ff.queued_count     <= 5'(count_in);
         if (stat.is_add) begin
            rsp_ff.status <= stat.full ? pjs_pkg::ST_FULL : pjs_pkg::ST_ADDED;
         end else if (stat.empty) begin
            rsp_ff.status <= pjs_pkg::ST_IDLE;
         end else begin
            rsp_ff.running_tag <= head.tag;
            if (final_slice) begin
               rsp_ff.status <= pjs_pkg::ST_FINAL;
            end else begin
               rsp_ff.status           <= pjs_pkg::ST_RAN;
               rsp_ff.remaining_length <= head.length - 16'd1;
            end
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pjs_pkg::CNT_W'(pjs_pkg::QUEUE_DEPTH))
      else $error("job count beyond depth");
   a_no_ins_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !stat.full)
      else $error("insert into full store");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !stat.empty)
      else $error("pop from empty store");
`endif

endmodule

[rtl/core/pjs_ctrl.sv]
// controller: sequences capture, search, update and response
module pjs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pjs_pkg::stat_type stat,
   output pjs_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_EXEC   = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      req_fire;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RESP;
   assign req_fire  = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (!stat.is_add || stat.full || stat.search_done) begin
               state_in = S_EXEC;
            end else begin
               cmd.search = 1'b1;
            end
         end
         S_EXEC: begin
            cmd.respond = 1'b1;
            if (stat.is_add) begin
               cmd.insert = !stat.full;
            end else if (!stat.empty) begin
               cmd.pop = stat.head_final;
               cmd.dec = !stat.head_final;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped");
   a_exec_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> rsp_valid)
      else $error("response not shown after execute");
`endif

endmodule

[rtl/core/priority_job_slice_scheduler_top.sv]
// Top level of the priority job slice scheduler.
// A tick or dropped add goes from request to response without a search; an add first
// searches past the stored jobs ahead of its insertion point (0 to QUEUE_DEPTH - 1).
// One request at a time; the next is taken in the cycle after the response leaves.
// Reset (synchronous, active high) empties the store and returns to idle.
module priority_job_slice_scheduler_top (
   input logic  clock,
   input logic  reset,
   pjs_req_if.sink   req,
   pjs_rsp_if.source rsp
);

   pjs_pkg::cmd_type  cmd;
   pjs_pkg::stat_type stat;

   pjs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pjs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req.payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp.payload)
   );

endmodule
